[design/pksjs_pkg.sv]
// ----------------------------------------------------------------------------
// pksjs_pkg
// Shared types and codes of the per-key serializing job scheduler: action and
// job kind codes, field widths and the packed queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pksjs_pkg;

  localparam int CONN_W = 8;
  localparam int KIND_W = 2;
  localparam int WORD_W = 32;

  // action codes
  localparam logic ACT_SUBMIT   = 1'b0;
  localparam logic ACT_COMPLETE = 1'b1;

  // job kind codes
  localparam logic [KIND_W-1:0] KIND_CONNECT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DISCONNECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RECEIVE    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SEND       = 2'd3;

  // one pending job as held in the queue memory
  typedef struct packed {
    logic [CONN_W-1:0] conn;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
  } entry_t;

endpackage

[design/pksjs_if.sv]
// ----------------------------------------------------------------------------
// pksjs_if
// Valid/ready channels of the scheduler: the item channel and the result
// channel, each with a source and a sink side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pksjs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [pksjs_pkg::CONN_W-1:0]  conn_id;
  logic [pksjs_pkg::KIND_W-1:0]  job_kind;
  logic [pksjs_pkg::WORD_W-1:0]  payload_word_a;
  logic [pksjs_pkg::WORD_W-1:0]  payload_word_b;

  modport source (
    output valid, action, conn_id, job_kind, payload_word_a, payload_word_b,
    input  ready
  );
  modport sink (
    input  valid, action, conn_id, job_kind, payload_word_a, payload_word_b,
    output ready
  );
endinterface

interface pksjs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          issued;
  logic [pksjs_pkg::CONN_W-1:0]  issued_conn_id;
  logic [pksjs_pkg::KIND_W-1:0]  issued_kind;
  logic [pksjs_pkg::WORD_W-1:0]  issued_word_a;
  logic [pksjs_pkg::WORD_W-1:0]  issued_word_b;
  logic                          dropped;

  modport source (
    output valid, issued, issued_conn_id, issued_kind, issued_word_a,
           issued_word_b, dropped,
    input  ready
  );
  modport sink (
    input  valid, issued, issued_conn_id, issued_kind, issued_word_a,
           issued_word_b, dropped,
    output ready
  );
endinterface

[design/pksjs_qram.sv]
// ----------------------------------------------------------------------------
// pksjs_qram
// Job queue storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pksjs_qram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_W-1:0]       waddr,
  input  pksjs_pkg::entry_t       wdata,
  input  logic                    re,
  input  logic [ADDR_W-1:0]       raddr,
  output pksjs_pkg::entry_t       rdata
);

  pksjs_pkg::entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/per_key_serializing_job_scheduler.sv]
// ----------------------------------------------------------------------------
// per_key_serializing_job_scheduler
// Ordered job queue with one busy bit per connection id; at most one job per
// connection is in flight. Connect jobs enter at the head, all other kinds at
// the tail. Every transaction on the item channel yields exactly one result
// transaction, which carries the job issued in that step (if any) and the
// drop flag of a refused submit. Items are taken one at a time: a submit is
// decided and its result emitted before the next item can be accepted; a
// completion walks the queue memory one entry per cycle through its single
// read port to find the first job of the freed connection and to close the
// gap behind it, and only then emits its result. A result that waits on the
// output stalls the block only until it is taken. After reset the busy map
// memory is cleared in a pass over its 2**ID_BITS entries, during which no
// item is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_key_serializing_job_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  pksjs_in_if.sink      in_chan,
  pksjs_out_if.source   out_chan
);

  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_COUNT = 1 << ID_BITS;
  localparam logic [pksjs_pkg::CONN_W-1:0] ConnMask =
    (ID_BITS >= pksjs_pkg::CONN_W) ? '1 : pksjs_pkg::CONN_W'((1 << ID_BITS) - 1);
  localparam logic [PTR_W-1:0] PtrLast  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CntFull  = CNT_W'(QUEUE_DEPTH);

  // sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PtrLast) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PtrLast : PTR_W'(p - 1'b1);
  endfunction

  // control state
  logic [2:0]         state_r, state_nxt;
  logic [ID_BITS-1:0] clr_r, clr_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic               found_r, found_nxt;
  logic               out_valid_r, out_valid_nxt;

  // latched item
  logic                           act_r, act_nxt;
  logic [pksjs_pkg::CONN_W-1:0]   conn_r, conn_nxt;
  logic [pksjs_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [pksjs_pkg::WORD_W-1:0]   wa_r, wa_nxt;
  logic [pksjs_pkg::WORD_W-1:0]   wb_r, wb_nxt;

  // pending result and output register
  logic               res_issued_r, res_issued_nxt;
  logic               res_drop_r, res_drop_nxt;
  pksjs_pkg::entry_t  res_job_r, res_job_nxt;
  logic               out_issued_r, out_issued_nxt;
  logic               out_drop_r, out_drop_nxt;
  pksjs_pkg::entry_t  out_job_r, out_job_nxt;

  // busy map memory
  logic               busy_mem [ID_COUNT];
  logic               busy_rd_r;
  logic               busy_we;
  logic [ID_BITS-1:0] busy_wa;
  logic               busy_wd;

  // queue memory ports
  logic               q_we, q_re;
  logic [PTR_W-1:0]   q_waddr, q_raddr;
  pksjs_pkg::entry_t  q_wdata, q_rdata;

  logic               in_fire;
  logic               scan_last;
  logic               scan_hit;
  pksjs_pkg::entry_t  item_job;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign item_job  = '{conn: conn_r, kind: kind_r, word_a: wa_r, word_b: wb_r};
  assign scan_last = (CNT_W'(j_r + 1'b1) == count_r);
  assign scan_hit  = !found_r && (q_rdata.conn == conn_r);

  pksjs_qram #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (PTR_W)
  ) u_qram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // busy map: read on acceptance, written by the sequencer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      busy_rd_r <= busy_mem[ID_BITS'(in_chan.conn_id & ConnMask)];
    end
    if (busy_we) begin
      busy_mem[busy_wa] <= busy_wd;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    j_nxt          = j_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r;
    act_nxt        = act_r;
    conn_nxt       = conn_r;
    kind_nxt       = kind_r;
    wa_nxt         = wa_r;
    wb_nxt         = wb_r;
    res_issued_nxt = res_issued_r;
    res_drop_nxt   = res_drop_r;
    res_job_nxt    = res_job_r;
    out_issued_nxt = out_issued_r;
    out_drop_nxt   = out_drop_r;
    out_job_nxt    = out_job_r;
    busy_we        = 1'b0;
    busy_wa        = ID_BITS'(conn_r);
    busy_wd        = 1'b0;
    q_we           = 1'b0;
    q_waddr        = tail_r;
    q_wdata        = item_job;
    q_re           = 1'b0;
    q_raddr        = head_r;

    // result leaves the output register
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        busy_we = 1'b1;
        busy_wa = clr_r;
        busy_wd = 1'b0;
        clr_nxt = ID_BITS'(clr_r + 1'b1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          act_nxt   = in_chan.action;
          conn_nxt  = in_chan.conn_id & ConnMask;
          kind_nxt  = in_chan.job_kind;
          wa_nxt    = in_chan.payload_word_a;
          wb_nxt    = in_chan.payload_word_b;
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_issued_nxt = 1'b0;
        res_drop_nxt   = 1'b0;
        res_job_nxt    = '0;
        state_nxt      = S_EMIT;
        if (act_r == pksjs_pkg::ACT_COMPLETE) begin
          // free the connection, then walk the queue for its first job
          busy_we = 1'b1;
          busy_wd = 1'b0;
          if (count_r != '0) begin
            q_re       = 1'b1;
            q_raddr    = head_r;
            rd_ptr_nxt = head_r;
            j_nxt      = '0;
            found_nxt  = 1'b0;
            state_nxt  = S_SCAN;
          end
        end else if (count_r == CntFull) begin
          res_drop_nxt = 1'b1;
        end else if (!busy_rd_r) begin
          // every queued job is blocked, so a free submit goes straight out
          busy_we        = 1'b1;
          busy_wd        = 1'b1;
          res_issued_nxt = 1'b1;
          res_job_nxt    = item_job;
        end else if (kind_r == pksjs_pkg::KIND_CONNECT) begin
          q_we      = 1'b1;
          q_waddr   = ptr_dec(head_r);
          head_nxt  = ptr_dec(head_r);
          count_nxt = CNT_W'(count_r + 1'b1);
        end else begin
          q_we      = 1'b1;
          q_waddr   = tail_r;
          tail_nxt  = ptr_inc(tail_r);
          count_nxt = CNT_W'(count_r + 1'b1);
        end
      end

      S_SCAN: begin
        // read data holds the entry at position j_r
        if (scan_hit) begin
          found_nxt      = 1'b1;
          busy_we        = 1'b1;
          busy_wd        = 1'b1;
          res_issued_nxt = 1'b1;
          res_job_nxt    = q_rdata;
        end else if (found_r) begin
          // close the gap: move this entry one place toward the head
          q_we    = 1'b1;
          q_waddr = ptr_dec(rd_ptr_r);
          q_wdata = q_rdata;
        end
        if (scan_last) begin
          state_nxt = S_EMIT;
          if (found_r || scan_hit) begin
            count_nxt = CNT_W'(count_r - 1'b1);
            tail_nxt  = ptr_dec(tail_r);
          end
        end else begin
          q_re       = 1'b1;
          q_raddr    = ptr_inc(rd_ptr_r);
          rd_ptr_nxt = ptr_inc(rd_ptr_r);
          j_nxt      = CNT_W'(j_r + 1'b1);
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_issued_nxt = res_issued_r;
          out_drop_nxt   = res_drop_r;
          out_job_nxt    = res_job_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rd_ptr_r    <= '0;
      j_r         <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      j_r         <= j_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    conn_r       <= conn_nxt;
    kind_r       <= kind_nxt;
    wa_r         <= wa_nxt;
    wb_r         <= wb_nxt;
    res_issued_r <= res_issued_nxt;
    res_drop_r   <= res_drop_nxt;
    res_job_r    <= res_job_nxt;
    out_issued_r <= out_issued_nxt;
    out_drop_r   <= out_drop_nxt;
    out_job_r    <= out_job_nxt;
  end

  // result channel
  assign out_chan.valid          = out_valid_r;
  assign out_chan.issued         = out_issued_r;
  assign out_chan.issued_conn_id = out_job_r.conn;
  assign out_chan.issued_kind    = out_job_r.kind;
  assign out_chan.issued_word_a  = out_job_r.word_a;
  assign out_chan.issued_word_b  = out_job_r.word_b;
  assign out_chan.dropped        = out_drop_r;

`ifndef SYNTHESIS
  // queue occupancy never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntFull)
    else $error("queue count above depth");

  // one transaction moves the occupancy by at most one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ((count_r == CNT_W'($past(count_r) + 1'b1)) ||
       (CNT_W'(count_r + 1'b1) == $past(count_r))))
    else $error("queue count jumped");

  // tail sits count entries past head, modulo the depth
  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (((CNT_W+1)'(head_r) + (CNT_W+1)'(count_r)) == (CNT_W+1)'(tail_r)) ||
    (((CNT_W+1)'(head_r) + (CNT_W+1)'(count_r)) ==
      ((CNT_W+1)'(tail_r) + (CNT_W+1)'(QUEUE_DEPTH))))
    else $error("head, tail and count disagree");

  // a refused submit never hands out a job in the same step
  a_drop_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !(out_chan.issued && out_chan.dropped))
    else $error("issue and drop in one result");
`endif

endmodule
